// ----- design/cis_pkg.sv -----
// cis_pkg: shared types, constants and codes for the collapsing issue window
// no dependencies; imported by cis_ctrl, cis_datapath and collapsing_issue_window
package cis_pkg;

  localparam int Depth         = 6;
  localparam int NumRegs       = 32;
  localparam int WriteSlotBits = 16;
  localparam int NumCfgRegs    = 8;

  localparam int IdxW     = $clog2(Depth);
  localparam int CntW     = $clog2(Depth + 1);
  localparam int RegW     = $clog2(NumRegs);
  localparam int SlotW    = $clog2(WriteSlotBits);
  localparam int CfgIdxW  = $clog2(NumCfgRegs);
  localparam int LatW     = 4;
  localparam int SlotIdxW = LatW + 1;

  localparam logic [2:0]          FloatClass = 3'd6;
  localparam logic [SlotIdxW-1:0] SlotOffset = SlotIdxW'(2);
  localparam logic [LatW-1:0]     LatReset   = LatW'(1);

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_ISSUE = 1'b1
  } cis_req_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_ISSUED   = 3'd2,
    ST_NONE_RDY = 3'd3,
    ST_EMPTY    = 3'd4
  } cis_status_e;

  typedef enum logic {
    CIS_IDLE = 1'b0,
    CIS_EXEC = 1'b1
  } cis_state_e;

  typedef struct packed {
    logic                     req_type;
    logic [2:0]               op_class;
    logic [RegW-1:0]          src_a;
    logic [RegW-1:0]          src_b;
    logic [RegW-1:0]          src_c;
    logic [2:0]               src_used;
    logic                     writes_dest;
    logic [RegW-1:0]          dest_reg;
    logic [15:0]              instr_tag;
    logic [NumRegs-1:0]       reg_ready;
    logic [WriteSlotBits-1:0] write_slots;
    logic                     float_free;
  } cis_req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [2:0]      out_op_class;
    logic [RegW-1:0] out_src_a;
    logic [RegW-1:0] out_src_b;
    logic [RegW-1:0] out_src_c;
    logic [2:0]      out_src_used;
    logic            out_writes_dest;
    logic [RegW-1:0] out_dest_reg;
    logic [15:0]     out_tag;
    logic [2:0]      occupancy;
    logic            window_full;
  } cis_res_t;

  typedef struct packed {
    logic [2:0]      op_class;
    logic [RegW-1:0] src_a;
    logic [RegW-1:0] src_b;
    logic [RegW-1:0] src_c;
    logic [2:0]      src_used;
    logic            writes_dest;
    logic [RegW-1:0] dest_reg;
    logic [15:0]     tag;
  } cis_entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cis_cmd_t;

endpackage

// ----- design/collapsing_issue_window.sv -----
// collapsing_issue_window: top level of the in-order compacting issue window
// depends on cis_pkg, cis_ctrl and cis_datapath
//
// usage
// - request channel: drive req_i and raise start_i; the transfer happens at the
//   rising edge where start_i is high and busy_o is low
// - req_type add appends an instruction at the tail (status full when no room);
//   req_type issue picks the oldest entry whose sources are ready, whose write
//   slot at class latency plus two is free, and, for float class, whose float
//   path is free; younger entries then move down one place
// - result channel: done_o is high for exactly one cycle with res_o valid; the
//   receiver takes it in that cycle and cannot stall it
// - result timing: the sequencer enters its execute state at the transfer edge;
//   done_o and res_o are registered at the end of that execute state
// - busy_o is high during the execute state of the sequencer, so no request is
//   taken then; a new request may be taken while a result is being shown
// - configuration: cfg_we_i writes the per-class write-back latency selected by
//   cfg_idx_i; write only while the block is idle
// - reset: the window is emptied, all latencies return to one, no result pending
module collapsing_issue_window (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  cis_pkg::cis_req_t            req_i,
  output logic                         done_o,
  output cis_pkg::cis_res_t            res_o,
  input  logic                         cfg_we_i,
  input  logic [cis_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cis_pkg::LatW-1:0]     cfg_wdata_i
);
  import cis_pkg::*;

  cis_cmd_t cmd;

  // sequencer: load on transfer, execute the next cycle
  cis_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  // window storage, select, collapse and result register
  cis_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .res_o       (res_o)
  );

  // every execute cycle is followed by exactly one result strobe
  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> done_o)
    else $error("execute cycle without result strobe");

  // the strobe never lands while the sequencer is still executing
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !cmd.exec)
    else $error("result strobe during execute");

endmodule

// ----- design/cis_ctrl.sv -----
// cis_ctrl: two-state sequencer that takes a request and runs its execute state
// depends on cis_pkg
module cis_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output cis_pkg::cis_cmd_t cmd_o
);
  import cis_pkg::*;

  cis_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CIS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CIS_IDLE: begin
        if (start_i) state_d = CIS_EXEC;
      end
      CIS_EXEC: begin
        state_d = CIS_IDLE;
      end
      default: begin
        state_d = CIS_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o     = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    case (state_q)
      CIS_IDLE: begin
        cmd_o.load = start_i;
      end
      CIS_EXEC: begin
        busy_o     = 1'b1;
        cmd_o.exec = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- design/cis_datapath.sv -----
// cis_datapath: window entries, entry count, latency registers, oldest-first select
// depends on cis_pkg
module cis_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cis_pkg::cis_cmd_t            cmd_i,
  input  cis_pkg::cis_req_t            req_i,
  input  logic                         cfg_we_i,
  input  logic [cis_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cis_pkg::LatW-1:0]     cfg_wdata_i,
  output logic                         done_o,
  output cis_pkg::cis_res_t            res_o
);
  import cis_pkg::*;

  cis_req_t            req_q;
  cis_entry_t          entry_q [Depth];
  logic [CntW-1:0]     count_q;
  logic [LatW-1:0]     lat_q [NumCfgRegs];
  logic                done_q;
  cis_res_t            res_q, res_d;

  logic [NumCfgRegs-1:0] class_busy;
  logic [Depth-1:0]      can_issue;
  logic [IdxW-1:0]       sel;
  logic                  found;
  logic                  is_full;
  logic                  do_add;
  logic                  do_issue;
  cis_entry_t            new_entry;
  cis_entry_t            pick;

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
  end

  // latency registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumCfgRegs; c++) lat_q[c] <= LatReset;
    end else if (cfg_we_i) begin
      lat_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // per-class write slot check, each latency read at its own place
  always_comb begin
    logic [SlotIdxW-1:0] n;
    for (int c = 0; c < NumCfgRegs; c++) begin
      n = {1'b0, lat_q[c]} + SlotOffset;
      if (n < SlotIdxW'(WriteSlotBits)) class_busy[c] = req_q.write_slots[n[SlotW-1:0]];
      else class_busy[c] = 1'b0;
    end
  end

  // readiness of every held entry
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      can_issue[i] = (CntW'(i) < count_q)
        && (!entry_q[i].src_used[0] || req_q.reg_ready[entry_q[i].src_a])
        && (!entry_q[i].src_used[1] || req_q.reg_ready[entry_q[i].src_b])
        && (!entry_q[i].src_used[2] || req_q.reg_ready[entry_q[i].src_c])
        && (!entry_q[i].writes_dest || !class_busy[entry_q[i].op_class])
        && (entry_q[i].op_class != FloatClass || req_q.float_free);
    end
  end

  // oldest ready entry wins
  always_comb begin
    sel = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (can_issue[i]) sel = IdxW'(i);
    end
  end

  assign found    = |can_issue;
  assign is_full  = (count_q == CntW'(Depth));
  assign do_add   = cmd_i.exec && (req_q.req_type == REQ_ADD) && !is_full;
  assign do_issue = cmd_i.exec && (req_q.req_type == REQ_ISSUE) && found;
  assign pick     = entry_q[sel];

  always_comb begin
    new_entry.op_class    = req_q.op_class;
    new_entry.src_a       = req_q.src_a;
    new_entry.src_b       = req_q.src_b;
    new_entry.src_c       = req_q.src_c;
    new_entry.src_used    = req_q.src_used;
    new_entry.writes_dest = req_q.writes_dest;
    new_entry.dest_reg    = req_q.dest_reg;
    new_entry.tag         = req_q.instr_tag;
  end

  // append at tail, or collapse younger entries over the issued one
  always_ff @(posedge clk_i) begin
    if (do_add) begin
      entry_q[count_q[IdxW-1:0]] <= new_entry;
    end else if (do_issue) begin
      for (int i = 0; i < Depth - 1; i++) begin
        if (IdxW'(i) >= sel) entry_q[i] <= entry_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (do_add) begin
      count_q <= count_q + CntW'(1);
    end else if (do_issue) begin
      count_q <= count_q - CntW'(1);
    end
  end

  always_comb begin
    logic [CntW-1:0] cnt_next;
    cis_status_e     st;
    res_d    = '0;
    cnt_next = count_q;
    if (req_q.req_type == REQ_ADD) begin
      if (is_full) begin
        st = ST_FULL;
      end else begin
        st       = ST_ADDED;
        cnt_next = count_q + CntW'(1);
      end
    end else if (count_q == '0) begin
      st = ST_EMPTY;
    end else if (found) begin
      st                    = ST_ISSUED;
      cnt_next              = count_q - CntW'(1);
      res_d.out_op_class    = pick.op_class;
      res_d.out_src_a       = pick.src_a;
      res_d.out_src_b       = pick.src_b;
      res_d.out_src_c       = pick.src_c;
      res_d.out_src_used    = pick.src_used;
      res_d.out_writes_dest = pick.writes_dest;
      res_d.out_dest_reg    = pick.dest_reg;
      res_d.out_tag         = pick.tag;
    end else begin
      st = ST_NONE_RDY;
    end
    res_d.status      = st;
    res_d.occupancy   = 3'(cnt_next);
    res_d.window_full = (cnt_next == CntW'(Depth));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.exec;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count beyond window depth");

  a_issue_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && res_q.status == ST_ISSUED |-> count_q == $past(count_q) - CntW'(1))
    else $error("issue did not remove one entry");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && res_q.status == ST_ADDED |-> count_q == $past(count_q) + CntW'(1))
    else $error("add did not append one entry");

  a_occ_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> res_q.occupancy == 3'(count_q))
    else $error("reported occupancy differs from entry count");

endmodule
